>>> sv/tmr_pkg.sv
// shared types and constants of the prescaled countdown timer bank
// no dependencies; imported by every other file of the block
package tmr_pkg;

    localparam int N_TIMERS_DEF = 16;
    localparam int DATA_W       = 16;
    localparam int FUNC_W       = 3;
    localparam int IDX_W        = 4;
    localparam int KIND_W       = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 3'd0,
        FN_LOAD    = 3'd1,
        FN_START   = 3'd2,
        FN_STOP    = 3'd3,
        FN_STOPALL = 3'd4,
        FN_READ    = 3'd5
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_END     = 2'd0,
        KIND_ALL_END = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_CHK,
        ST_RD,
        ST_WR,
        ST_FIN,
        ST_FIN2
    } t_state;

endpackage

>>> sv/tmr_cmd_if.sv
// command channel of the timer bank
// depends on tmr_pkg for field widths
interface tmr_cmd_if
    import tmr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  timer_sel;
    logic [DATA_W-1:0] count_value;

    modport source (output valid, output func, output timer_sel, output count_value,
                    input ready);
    modport sink   (input valid, input func, input timer_sel, input count_value,
                    output ready);
endinterface

>>> sv/tmr_rsp_if.sv
// result channel of the timer bank
// depends on tmr_pkg for field widths
interface tmr_rsp_if
    import tmr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  which_timer;
    logic [DATA_W-1:0] read_count;
    logic              read_running;
    logic              last;

    modport source (output valid, output kind, output which_timer, output read_count,
                    output read_running, output last, input ready);
    modport sink   (input valid, input kind, input which_timer, input read_count,
                    input read_running, input last, output ready);
endinterface

>>> sv/tmr_cfg_if.sv
// configuration write channel carrying the prescale reload value
// depends on tmr_pkg for the data width
interface tmr_cfg_if
    import tmr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] prescale_reload;

    modport source (output valid, output prescale_reload, input ready);
    modport sink   (input valid, input prescale_reload, output ready);
endinterface

>>> sv/tmr_mem.sv
// count storage: one write port, one registered read port, per-entry valid bits
// depends on tmr_pkg; an entry never written reads as zero
module tmr_mem
    import tmr_pkg::*;
#(
    parameter int N_TIMERS = N_TIMERS_DEF,
    parameter int AW       = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0]   r_mem [N_TIMERS];
    logic [N_TIMERS-1:0] r_vld;
    logic [DATA_W-1:0]   r_rdata;
    logic                r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

>>> sv/tmr_ctrl.sv
// command sequencer: prescaler, running flags, timer walk with one shared decrementer,
// result register; depends on tmr_pkg, tmr_cmd_if, tmr_rsp_if and the tmr_mem ports
module tmr_ctrl
    import tmr_pkg::*;
#(
    parameter int N_TIMERS = N_TIMERS_DEF,
    parameter int AW       = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tmr_cmd_if.sink           i_cmd,
    tmr_rsp_if.source         o_rsp,
    input  logic [DATA_W-1:0] i_prescale_reload,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic              o_we,
    output logic [AW-1:0]     o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data
);

    t_state r_state, n_state;

    logic [FUNC_W-1:0]   r_func;
    logic [IDX_W-1:0]    r_idx;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_pleft;
    logic [N_TIMERS-1:0] r_running;
    logic [AW-1:0]       r_i;
    logic                r_stepped;
    logic                r_allend;
    logic                r_pend;
    logic [AW-1:0]       r_pidx;

    logic              r_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [IDX_W-1:0]  r_owhich;
    logic [DATA_W-1:0] r_ocount;
    logic              r_orun;
    logic              r_olast;

    logic [AW-1:0]     idx_a;
    logic              idx_ok;
    logic              last_i;
    logic              out_free;
    logic [DATA_W-1:0] dec;
    logic              dec_zero;
    logic              wr_go;

    logic              emit;
    t_kind             e_kind;
    logic [IDX_W-1:0]  e_which;
    logic [DATA_W-1:0] e_count;
    logic              e_run;
    logic              e_last;
    logic              f_pre_dec;
    logic              f_walk_init;
    logic              f_step;
    logic              f_inc;
    logic              run_set;
    logic              run_clr;
    logic              clr_all;
    logic [AW-1:0]     run_idx;

    assign idx_a    = AW'(r_idx);
    assign idx_ok   = 32'(r_idx) < N_TIMERS;
    assign last_i   = r_i == AW'(N_TIMERS - 1);
    assign out_free = !r_ovalid || o_rsp.ready;
    assign dec      = i_rd_data - DATA_W'(1);
    assign dec_zero = dec == '0;
    assign wr_go    = !(dec_zero && r_pend && !out_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                unique case (t_func'(r_func))
                    FN_TICK: begin
                        if (r_pleft != '0 || r_running == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                    FN_START: n_state = idx_ok ? ST_CHK : ST_IDLE;
                    FN_READ:  n_state = ST_CHK;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_CHK: begin
                if ((t_func'(r_func) == FN_START && i_rd_data != '0) || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                if (r_running[r_i]) begin
                    n_state = ST_WR;
                end else if (last_i) begin
                    n_state = ST_FIN;
                end
            end
            ST_WR: begin
                if (wr_go) begin
                    n_state = last_i ? ST_FIN : ST_RD;
                end
            end
            ST_FIN: begin
                if (!r_stepped) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_state = (r_pend && r_allend) ? ST_FIN2 : ST_IDLE;
                end
            end
            ST_FIN2: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and update strobes
    always_comb begin
        i_cmd.ready = 1'b0;
        o_rd_addr   = r_i;
        o_we        = 1'b0;
        o_wr_addr   = r_i;
        o_wr_data   = dec;
        emit        = 1'b0;
        e_kind      = KIND_TICK;
        e_which     = '0;
        e_count     = '0;
        e_run       = 1'b0;
        e_last      = 1'b0;
        f_pre_dec   = 1'b0;
        f_walk_init = 1'b0;
        f_step      = 1'b0;
        f_inc       = 1'b0;
        run_set     = 1'b0;
        run_clr     = 1'b0;
        clr_all     = 1'b0;
        run_idx     = r_i;
        unique case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
            end
            ST_CMD: begin
                run_idx = idx_a;
                unique case (t_func'(r_func))
                    FN_TICK: begin
                        if (r_pleft != '0) begin
                            f_pre_dec = 1'b1;
                        end else begin
                            f_walk_init = 1'b1;
                        end
                    end
                    FN_LOAD: begin
                        if (idx_ok) begin
                            o_we      = 1'b1;
                            o_wr_addr = idx_a;
                            o_wr_data = r_val;
                            run_clr   = 1'b1;
                        end
                    end
                    FN_START, FN_READ: begin
                        o_rd_addr = idx_a;
                    end
                    FN_STOP: begin
                        run_clr = idx_ok;
                    end
                    FN_STOPALL: begin
                        clr_all = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_CHK: begin
                o_rd_addr = idx_a;
                run_idx   = idx_a;
                e_which   = r_idx;
                e_last    = 1'b1;
                if (t_func'(r_func) == FN_START) begin
                    e_kind = KIND_END;
                    if (i_rd_data != '0) begin
                        run_set = 1'b1;
                    end else if (out_free) begin
                        emit    = 1'b1;
                        run_clr = 1'b1;
                    end
                end else begin
                    e_kind  = KIND_READ;
                    e_count = idx_ok ? i_rd_data : '0;
                    e_run   = idx_ok && r_running[idx_a];
                    emit    = out_free;
                end
            end
            ST_RD: begin
                f_inc = !r_running[r_i] && !last_i;
            end
            ST_WR: begin
                e_kind  = KIND_END;
                e_which = IDX_W'(r_pidx);
                if (wr_go) begin
                    o_we    = 1'b1;
                    f_step  = 1'b1;
                    f_inc   = !last_i;
                    run_clr = dec_zero;
                    emit    = dec_zero && r_pend;
                end
            end
            ST_FIN: begin
                e_which = IDX_W'(r_pidx);
                if (r_stepped && out_free) begin
                    emit = 1'b1;
                    if (r_pend) begin
                        e_kind = KIND_END;
                        e_last = !r_allend;
                    end else begin
                        e_kind  = KIND_TICK;
                        e_which = '0;
                        e_last  = 1'b1;
                    end
                end
            end
            ST_FIN2: begin
                e_kind = KIND_ALL_END;
                e_last = 1'b1;
                emit   = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pleft   <= '0;
            r_running <= '0;
            r_ovalid  <= 1'b0;
            r_i       <= '0;
            r_stepped <= 1'b0;
            r_allend  <= 1'b1;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (f_pre_dec) begin
                r_pleft <= r_pleft - DATA_W'(1);
            end else if (f_walk_init) begin
                r_pleft <= i_prescale_reload;
            end
            if (clr_all) begin
                r_running <= '0;
            end else if (run_clr) begin
                r_running[run_idx] <= 1'b0;
            end else if (run_set) begin
                r_running[run_idx] <= 1'b1;
            end
            if (f_walk_init) begin
                r_i       <= '0;
                r_stepped <= 1'b0;
                r_allend  <= 1'b1;
                r_pend    <= 1'b0;
            end else begin
                if (f_inc) begin
                    r_i <= r_i + AW'(1);
                end
                if (f_step) begin
                    r_stepped <= 1'b1;
                    if (dec_zero) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_allend <= 1'b0;
                    end
                end
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_func <= i_cmd.func;
            r_idx  <= i_cmd.timer_sel;
            r_val  <= i_cmd.count_value;
        end
        if (f_step && dec_zero) begin
            r_pidx <= r_i;
        end
        if (emit) begin
            r_okind  <= e_kind;
            r_owhich <= e_which;
            r_ocount <= e_count;
            r_orun   <= e_run;
            r_olast  <= e_last;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.kind         = r_okind;
    assign o_rsp.which_timer  = r_owhich;
    assign o_rsp.read_count   = r_ocount;
    assign o_rsp.read_running = r_orun;
    assign o_rsp.last         = r_olast;

endmodule

>>> sv/prescaled_countdown_timer_bank.sv
// Bank of N_TIMERS 16-bit down-counting timers behind one prescaler. Commands arrive one
// at a time on i_cmd; results leave on o_rsp, with last set on the final result of a command.
// Start and read may wait on o_rsp; load, stop and stop-all return no result and never wait.
// A tick that only counts down the prescaler, or finds no timer running, does not walk the bank.
// A tick that steps the timers walks the bank through the single decrementer and the one
// read port of the count memory, adds an all-end result when every stepped timer ends,
// and stalls while o_rsp is held.
// The prescale reload value is written on i_cfg, which is always ready.
// depends on tmr_pkg, tmr_cmd_if, tmr_rsp_if, tmr_cfg_if, tmr_mem, tmr_ctrl
module prescaled_countdown_timer_bank
    import tmr_pkg::*;
#(
    parameter int N_TIMERS = N_TIMERS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmr_cmd_if.sink   i_cmd,
    tmr_rsp_if.source o_rsp,
    tmr_cfg_if.sink   i_cfg
);

    localparam int AW = (N_TIMERS > 1) ? $clog2(N_TIMERS) : 1;

    logic [DATA_W-1:0] r_prescale_reload;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_reload <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_prescale_reload <= i_cfg.prescale_reload;
        end
    end

    tmr_mem #(
        .N_TIMERS (N_TIMERS),
        .AW       (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    tmr_ctrl #(
        .N_TIMERS (N_TIMERS),
        .AW       (AW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (i_cmd),
        .o_rsp             (o_rsp),
        .i_prescale_reload (r_prescale_reload),
        .o_rd_addr         (rd_addr),
        .i_rd_data         (rd_data),
        .o_we              (we),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data)
    );

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while busy");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_READ) |-> o_rsp.last)
        else $error("read reply not last");

    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.kind == KIND_TICK || o_rsp.kind == KIND_ALL_END))
        |-> (o_rsp.last && o_rsp.which_timer == '0))
        else $error("tick summary malformed");

    a_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind != KIND_READ)
        |-> (o_rsp.read_count == '0 && !o_rsp.read_running))
        else $error("read fields set on non-read result");

endmodule
